FILE: design/ptm_pkg.sv
package ptm_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int COLOR_W             = 16;
    localparam int INDEX_W             = 8;
    localparam int BYTE_W              = 8;
    localparam int GRAD_W              = 4;
    localparam int CFG_INDEX_W         = 3;

    localparam logic [INDEX_W-1:0] MATERIAL_BASE = 8'd192;
    localparam logic [COLOR_W-1:0] COLOR_KEY     = 16'hF81F;

    localparam logic CMD_PALETTE_WRITE = 1'b0;
    localparam logic CMD_PIXEL         = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_MATERIAL_A = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MATERIAL_B = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MATERIAL_C = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MATERIAL_D = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MASK_ENABLE = 3'd4;

    typedef struct packed {
        logic               cmd;
        logic [INDEX_W-1:0] index;
        logic [BYTE_W-1:0]  red_in;
        logic [BYTE_W-1:0]  green_in;
        logic [BYTE_W-1:0]  blue_in;
    } req_t;

    typedef struct packed {
        logic [COLOR_W-1:0] pixel_color;
        logic               pixel_write;
    } rsp_t;

    function automatic logic [COLOR_W-1:0] pack565(
        input logic [BYTE_W-1:0] r,
        input logic [BYTE_W-1:0] g,
        input logic [BYTE_W-1:0] b
    );
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

    // floor(ch * grad / 8), clamped to 255
    function automatic logic [BYTE_W-1:0] scale_channel(
        input logic [BYTE_W-1:0] ch,
        input logic [GRAD_W-1:0] grad
    );
        logic [BYTE_W+GRAD_W-1:0] prod;
        logic [BYTE_W:0]          v;
        prod = {{GRAD_W{1'b0}}, ch} * {{BYTE_W{1'b0}}, grad};
        v    = prod[BYTE_W+GRAD_W-1:3];
        return v[BYTE_W] ? {BYTE_W{1'b1}} : v[BYTE_W-1:0];
    endfunction

endpackage

FILE: design/palette_tint_pixel_mapper_unit.sv
// Each accepted pixel word yields a result on rsp; palette writes and pixels
// may interleave freely. Throughput: one word per cycle unless rsp stalls.
// Stages: input register, palette RAM read / tint register, output register.
// Palette writes produce no result; the palette RAM is not cleared at reset.
// Reset (rst_n, async low): pipeline empty, material colors 0, masking on.
module palette_tint_pixel_mapper_unit
    import ptm_pkg::*;
    #(
        parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
    )
    (
        input  logic                   clk,
        input  logic                   rst_n,
        input  logic                   req_valid,
        output logic                   req_ready,
        input  req_t                   req,
        output logic                   rsp_valid,
        input  logic                   rsp_ready,
        output rsp_t                   rsp,
        input  logic                   cfg_valid,
        output logic                   cfg_ready,
        input  logic [CFG_INDEX_W-1:0] cfg_index,
        input  logic [COLOR_W-1:0]     cfg_data
    );

    localparam int ADDR_W = $clog2(PALETTE_ENTRIES);

    logic [COLOR_W-1:0] material_reg [4];
    logic               mask_enable_reg;

    logic               s1_valid_reg;
    req_t               s1_req_reg;
    logic               s2_valid_reg;
    logic               s2_material_reg;
    logic [COLOR_W-1:0] s2_tint_reg;
    logic               out_valid_reg;
    rsp_t               out_rsp_reg;

    logic               out_take;
    logic               s2_take;
    logic               s1_move;
    logic               s1_is_pixel;
    logic               s1_material;
    logic [COLOR_W-1:0] tint_color;
    logic [COLOR_W-1:0] pal_rdata;
    rsp_t               s2_rsp;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            material_reg[0] <= '0;
            material_reg[1] <= '0;
            material_reg[2] <= '0;
            material_reg[3] <= '0;
            mask_enable_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MATERIAL_A:  material_reg[0] <= cfg_data;
                CFG_MATERIAL_B:  material_reg[1] <= cfg_data;
                CFG_MATERIAL_C:  material_reg[2] <= cfg_data;
                CFG_MATERIAL_D:  material_reg[3] <= cfg_data;
                CFG_MASK_ENABLE: mask_enable_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // flow control
    assign out_take    = !out_valid_reg || rsp_ready;
    assign s2_take     = !s2_valid_reg || out_take;
    assign s1_is_pixel = (s1_req_reg.cmd == CMD_PIXEL);
    assign s1_move     = s1_valid_reg && (!s1_is_pixel || s2_take);
    assign req_ready   = !s1_valid_reg || s1_move;

    assign s1_material = (s1_req_reg.index >= MATERIAL_BASE);

    ptm_ram
        #(
            .WIDTH (COLOR_W),
            .DEPTH (PALETTE_ENTRIES)
        )
        u_palette
        (
            .clk   (clk),
            .we    (s1_move && !s1_is_pixel),
            .waddr (s1_req_reg.index[ADDR_W-1:0]),
            .wdata (pack565(s1_req_reg.red_in, s1_req_reg.green_in, s1_req_reg.blue_in)),
            .re    (s1_move && s1_is_pixel),
            .raddr (s1_req_reg.index[ADDR_W-1:0]),
            .rdata (pal_rdata)
        );

    ptm_tint u_tint
        (
            .base_color (material_reg[s1_req_reg.index[5:4]]),
            .grad       (s1_req_reg.index[GRAD_W-1:0]),
            .tint_color (tint_color)
        );

    always_comb
    begin
        s2_rsp = '0;
        if (s2_material_reg)
        begin
            s2_rsp.pixel_color = s2_tint_reg;
            s2_rsp.pixel_write = 1'b1;
        end
        else if (mask_enable_reg && pal_rdata == COLOR_KEY)
        begin
            s2_rsp.pixel_color = '0;
            s2_rsp.pixel_write = 1'b0;
        end
        else
        begin
            s2_rsp.pixel_color = pal_rdata;
            s2_rsp.pixel_write = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                s1_valid_reg <= req_valid;
            end
            if (s2_take)
            begin
                s2_valid_reg <= s1_valid_reg && s1_is_pixel;
            end
            if (out_take)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            s1_req_reg <= req;
        end
        if (s1_move && s1_is_pixel)
        begin
            s2_material_reg <= s1_material;
            s2_tint_reg     <= tint_color;
        end
        if (out_take && s2_valid_reg)
        begin
            out_rsp_reg <= s2_rsp;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_rsp_reg;

endmodule

FILE: design/ptm_ram.sv
module ptm_ram
    #(
        parameter int WIDTH = 16,
        parameter int DEPTH = 256
    )
    (
        input  logic                     clk,
        input  logic                     we,
        input  logic [$clog2(DEPTH)-1:0] waddr,
        input  logic [WIDTH-1:0]         wdata,
        input  logic                     re,
        input  logic [$clog2(DEPTH)-1:0] raddr,
        output logic [WIDTH-1:0]         rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/ptm_tint.sv
module ptm_tint
    import ptm_pkg::*;
    (
        input  logic [COLOR_W-1:0] base_color,
        input  logic [GRAD_W-1:0]  grad,
        output logic [COLOR_W-1:0] tint_color
    );

    logic [BYTE_W-1:0] r_exp;
    logic [BYTE_W-1:0] g_exp;
    logic [BYTE_W-1:0] b_exp;

    assign r_exp = {base_color[15:11], 3'b000};
    assign g_exp = {base_color[10:5], 2'b00};
    assign b_exp = {base_color[4:0], 3'b000};

    assign tint_color = pack565(scale_channel(r_exp, grad),
                                scale_channel(g_exp, grad),
                                scale_channel(b_exp, grad));

endmodule

FILE: design/ptm_checker.sv
module ptm_checker
    import ptm_pkg::*;
    (
        input logic clk,
        input logic rst_n,
        input logic req_ready,
        input logic rsp_valid,
        input logic rsp_ready,
        input rsp_t rsp
    );

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("rsp changed while stalled");

    a_masked_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.pixel_write |-> rsp.pixel_color == '0)
        else $error("masked pixel carries nonzero color");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("req stalled with empty output");

endmodule

bind palette_tint_pixel_mapper_unit ptm_checker u_ptm_checker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

FILE: test/tb_palette_tint_pixel_mapper_unit.sv
`timescale 1ns / 1ps

module tb_palette_tint_pixel_mapper_unit;
    import ptm_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES = 200;
    localparam int PHASE_WORDS = 150;
    localparam int PRESSURE_WORDS = 40;

    class tint_map_checker;
        logic [COLOR_W-1:0] palette [PALETTE_ENTRIES_DEF];
        logic [COLOR_W-1:0] tint [4];
        logic               mask_on;
        rsp_t               pixels_due [$];
        int                 errors;

        function new();
            foreach (tint[k])
                tint[k] = '0;
            mask_on = 1'b1;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [COLOR_W-1:0] data);
            case (idx)
                CFG_MATERIAL_A:  tint[0] = data;
                CFG_MATERIAL_B:  tint[1] = data;
                CFG_MATERIAL_C:  tint[2] = data;
                CFG_MATERIAL_D:  tint[3] = data;
                CFG_MASK_ENABLE: mask_on = data[0];
                default: ;
            endcase
        endfunction

        function logic [BYTE_W-1:0] scaled(logic [BYTE_W-1:0] ch, logic [GRAD_W-1:0] grad);
            int v;
            v = (int'(ch) * int'(grad)) >> 3;
            return (v > 255) ? 8'hFF : v[BYTE_W-1:0];
        endfunction

        function void note_word(req_t w);
            rsp_t               want;
            logic [COLOR_W-1:0] c;
            logic [BYTE_W-1:0]  r, g, b;
            if (w.cmd == CMD_PALETTE_WRITE) begin
                palette[w.index] = {w.red_in[7:3], w.green_in[7:2], w.blue_in[7:3]};
                return;
            end
            want.pixel_write = 1'b1;
            if (w.index >= MATERIAL_BASE) begin
                c = tint[w.index[5:4]];
                r = scaled({c[15:11], 3'b000}, w.index[3:0]);
                g = scaled({c[10:5], 2'b00}, w.index[3:0]);
                b = scaled({c[4:0], 3'b000}, w.index[3:0]);
                want.pixel_color = {r[7:3], g[7:2], b[7:3]};
            end
            else begin
                want.pixel_color = palette[w.index];
                if (mask_on && want.pixel_color == COLOR_KEY) begin
                    want.pixel_write = 1'b0;
                    want.pixel_color = '0;
                end
            end
            pixels_due.push_back(want);
        endfunction

        function void check_pixel(rsp_t got);
            rsp_t want;
            if (pixels_due.size() == 0) begin
                $display("%0t: unexpected pixel, expected none, got color %h write %b",
                         $time, got.pixel_color, got.pixel_write);
                errors++;
                return;
            end
            want = pixels_due.pop_front();
            if (got.pixel_color !== want.pixel_color) begin
                $display("%0t: pixel_color expected %h got %h",
                         $time, want.pixel_color, got.pixel_color);
                errors++;
            end
            if (got.pixel_write !== want.pixel_write) begin
                $display("%0t: pixel_write expected %b got %b",
                         $time, want.pixel_write, got.pixel_write);
                errors++;
            end
        endfunction

        function int pending();
            return pixels_due.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_ready;
    req_t                   req = '0;
    logic                   rsp_valid;
    logic                   rsp_ready = 1'b0;
    rsp_t                   rsp;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [COLOR_W-1:0]     cfg_data = '0;

    tint_map_checker sb = new();

    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;
    bit          filled [PALETTE_ENTRIES_DEF];
    logic [7:0]  filled_q [$];

    palette_tint_pixel_mapper_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    always @(negedge clk)
    begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
        end
        else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_pixel(rsp);
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    function automatic req_t make_word(logic cmd, logic [7:0] idx,
                                       logic [7:0] r, logic [7:0] g, logic [7:0] b);
        req_t w;
        w.cmd = cmd;
        w.index = idx;
        w.red_in = r;
        w.green_in = g;
        w.blue_in = b;
        return w;
    endfunction

    function automatic req_t random_word();
        logic [7:0] idx;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 30) begin
            idx = ($urandom_range(99) < 80) ? 8'($urandom_range(191)) : 8'($urandom_range(255));
            if ($urandom_range(99) < 25)
                return make_word(CMD_PALETTE_WRITE, idx,
                                 {5'h1F, 3'($urandom_range(7))},
                                 {6'h00, 2'($urandom_range(3))},
                                 {5'h1F, 3'($urandom_range(7))});
            return make_word(CMD_PALETTE_WRITE, idx, 8'($urandom_range(255)),
                             8'($urandom_range(255)), 8'($urandom_range(255)));
        end
        if (pick < 65)
            idx = 8'($urandom_range(255, 192));
        else
            idx = filled_q[$urandom_range(filled_q.size() - 1)];
        return make_word(CMD_PIXEL, idx, 8'($urandom_range(255)),
                         8'($urandom_range(255)), 8'($urandom_range(255)));
    endfunction

    // entered and left at a falling edge; valid is left high for the caller
    task automatic send_word(input req_t w);
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= w;
        if (w.cmd == CMD_PALETTE_WRITE && w.index < MATERIAL_BASE && !filled[w.index]) begin
            filled[w.index] = 1'b1;
            filled_q.push_back(w.index);
        end
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        sb.note_word(w);
        @(negedge clk);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic configure(input logic [15:0] a, input logic [15:0] b,
                             input logic [15:0] c, input logic [15:0] d,
                             input logic [15:0] mask_word);
        logic [CFG_INDEX_W-1:0] idx [8];
        logic [COLOR_W-1:0]     val [8];
        idx = '{CFG_MATERIAL_A, CFG_MATERIAL_B, CFG_MATERIAL_C, CFG_MATERIAL_D,
                CFG_MASK_ENABLE, CFG_MASK_ENABLE + 3'd1, CFG_MASK_ENABLE + 3'd2,
                CFG_MASK_ENABLE + 3'd3};
        val = '{a, b, c, d, mask_word, 16'($urandom), 16'($urandom), 16'($urandom)};
        for (int k = 0; k < 8; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data <= val[k];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            sb.write_reg(idx[k], val[k]);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    int idle_tab [4] = '{0, 87, 0, 11};
    int stall_tab [4] = '{0, 0, 87, 11};

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        configure(16'hFFFF, 16'h0000, 16'h07E0, COLOR_KEY, 16'h0001);

        // corner words: palette extremes, color key, every tint band and gradient edge
        send_word(make_word(CMD_PALETTE_WRITE, 8'd0, 8'h00, 8'h00, 8'h00));
        send_word(make_word(CMD_PALETTE_WRITE, 8'd191, 8'hFF, 8'hFF, 8'hFF));
        send_word(make_word(CMD_PALETTE_WRITE, 8'd5, 8'hF8, 8'h00, 8'hF8));
        send_word(make_word(CMD_PALETTE_WRITE, 8'd255, 8'hA5, 8'h5A, 8'hC3));
        send_word(make_word(CMD_PIXEL, 8'd0, 8'hFF, 8'hFF, 8'hFF));
        send_word(make_word(CMD_PIXEL, 8'd191, 8'h00, 8'h00, 8'h00));
        send_word(make_word(CMD_PIXEL, 8'd5, 8'h00, 8'h00, 8'h00));
        send_word(make_word(CMD_PIXEL, 8'd192, 8'h00, 8'h00, 8'h00));
        send_word(make_word(CMD_PIXEL, 8'd200, 8'h00, 8'h00, 8'h00));
        send_word(make_word(CMD_PIXEL, 8'd207, 8'h00, 8'h00, 8'h00));
        send_word(make_word(CMD_PIXEL, 8'd208, 8'h00, 8'h00, 8'h00));
        send_word(make_word(CMD_PIXEL, 8'd223, 8'h00, 8'h00, 8'h00));
        send_word(make_word(CMD_PIXEL, 8'd224, 8'h00, 8'h00, 8'h00));
        send_word(make_word(CMD_PIXEL, 8'd239, 8'h00, 8'h00, 8'h00));
        send_word(make_word(CMD_PIXEL, 8'd240, 8'h00, 8'h00, 8'h00));
        send_word(make_word(CMD_PIXEL, 8'd255, 8'h00, 8'h00, 8'h00));
        // back-to-back write then read of the same entry
        send_word(make_word(CMD_PALETTE_WRITE, 8'd7, 8'h12, 8'h34, 8'h56));
        send_word(make_word(CMD_PALETTE_WRITE, 8'd7, 8'hFF, 8'h03, 8'hFF));
        send_word(make_word(CMD_PIXEL, 8'd7, 8'h00, 8'h00, 8'h00));
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: configure(16'h0000, 16'hFFFF, 16'hF81F, 16'($urandom), 16'hFFFE);
                1: configure(16'hFFFF, 16'($urandom), 16'h0000, 16'hFFFF, 16'h0001);
                default: configure(16'($urandom), 16'($urandom), 16'($urandom),
                                   16'($urandom), 16'($urandom));
            endcase
            send_idle_pct = idle_tab[ph];
            stall_pct = stall_tab[ph];
            send_word(make_word(CMD_PIXEL, 8'd5, 8'hFF, 8'hFF, 8'hFF));
            repeat (PHASE_WORDS) send_word(random_word());
            drain();
        end

        // long receiver hold while the sender keeps pushing
        configure(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'h0001);
        send_idle_pct = 0;
        stall_pct = 0;
        hold_left = HOLD_CYCLES;
        repeat (PRESSURE_WORDS) send_word(random_word());
        drain();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: filelist.f
design/ptm_pkg.sv
design/ptm_ram.sv
design/ptm_tint.sv
design/palette_tint_pixel_mapper_unit.sv
design/ptm_checker.sv
test/tb_palette_tint_pixel_mapper_unit.sv
